@@ src/smx_pkg.sv @@
// ----------------------------------------------------------------------------
// smx_pkg: shared definitions for the stack machine execute step
// Types, opcode and trap codes, and default sizes used by all modules.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int WORD_W      = 64;
    localparam int STACK_DEPTH = 1024;
    localparam int KIND_W      = 3;
    localparam int TRAP_W      = 3;
    localparam int DEPTH_OUT_W = 11;

    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

    localparam logic [TRAP_W-1:0] TRAP_NONE    = 3'd0;
    localparam logic [TRAP_W-1:0] TRAP_OVER    = 3'd1;
    localparam logic [TRAP_W-1:0] TRAP_UNDER   = 3'd2;
    localparam logic [TRAP_W-1:0] TRAP_ILLEGAL = 3'd3;
    localparam logic [TRAP_W-1:0] TRAP_DIVZERO = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] operand;
    } smx_cmd_t;

    typedef struct packed {
        logic [TRAP_W-1:0]        trap;
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_OUT_W-1:0]   depth;
    } smx_rsp_t;

    typedef enum logic [1:0] {
        AOP_ADD,
        AOP_SUB,
        AOP_MUL,
        AOP_DIV
    } smx_aop_t;

    typedef struct packed {
        logic     start;
        smx_aop_t op;
    } smx_alu_req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_BUSY,
        S_DONE
    } smx_state_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV_PREP,
        ALU_DIV,
        ALU_DIV_FIX
    } smx_alu_state_t;

endpackage

@@ src/stack_machine_execute_step.sv @@
// ----------------------------------------------------------------------------
// stack_machine_execute_step: one instruction of a 64-bit stack machine
// Push and trapping items go from accept straight to the registered response;
// add and subtract take one ALU step, multiply and divide run bit-serially in
// the shared arithmetic unit; one item is in work at a time.
// The top of stack lives in a register, the entries below it in a RAM.
// Reset empties the stack at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_machine_execute_step #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  smx_pkg::smx_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output smx_pkg::smx_rsp_t rsp
);

    localparam int W  = smx_pkg::WORD_W;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int OW = smx_pkg::DEPTH_OUT_W;

    smx_pkg::smx_state_t   state_reg, state_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [W-1:0]          top_reg, top_next;
    logic [smx_pkg::TRAP_W-1:0] trap_reg, trap_next;
    smx_pkg::smx_aop_t     aop_reg, aop_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    smx_pkg::smx_rsp_t     rsp_reg, rsp_next;

    smx_pkg::smx_alu_req_t alu_req;
    logic                  alu_done;
    logic [W-1:0]          alu_result;

    logic                  wr_en;
    logic                  rd_en;
    logic [DW-1:0]         wr_idx;
    logic [DW-1:0]         rd_idx;
    logic [W-1:0]          rd_data;
    logic [DW+OW-1:0]      depth_wide;

    assign wr_idx     = depth_reg - DW'(1);
    assign rd_idx     = depth_reg - DW'(2);
    assign depth_wide = {{OW{1'b0}}, depth_reg};

    smx_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (top_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    smx_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (rd_data),
        .b      (top_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smx_pkg::S_IDLE;
            depth_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        trap_reg <= trap_next;
        aop_reg  <= aop_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        top_next       = top_reg;
        trap_next      = trap_reg;
        aop_next       = aop_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.op     = aop_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            smx_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    state_next = smx_pkg::S_DONE;
                    unique case (cmd.kind) inside
                        smx_pkg::KIND_PUSH:
                        begin
                            if (depth_reg == DW'(STACK_DEPTH))
                            begin
                                trap_next = smx_pkg::TRAP_OVER;
                            end
                            else
                            begin
                                trap_next  = smx_pkg::TRAP_NONE;
                                wr_en      = (depth_reg != '0);
                                top_next   = cmd.operand;
                                depth_next = depth_reg + DW'(1);
                            end
                        end
                        smx_pkg::KIND_ADD, smx_pkg::KIND_SUB,
                        smx_pkg::KIND_MUL, smx_pkg::KIND_DIV:
                        begin
                            if (depth_reg < DW'(2))
                            begin
                                trap_next = smx_pkg::TRAP_UNDER;
                            end
                            else if (cmd.kind == smx_pkg::KIND_DIV && top_reg == '0)
                            begin
                                trap_next = smx_pkg::TRAP_DIVZERO;
                            end
                            else
                            begin
                                trap_next  = smx_pkg::TRAP_NONE;
                                rd_en      = 1'b1;
                                state_next = smx_pkg::S_LOAD;
                                unique case (cmd.kind)
                                    smx_pkg::KIND_ADD: aop_next = smx_pkg::AOP_ADD;
                                    smx_pkg::KIND_SUB: aop_next = smx_pkg::AOP_SUB;
                                    smx_pkg::KIND_MUL: aop_next = smx_pkg::AOP_MUL;
                                    default:           aop_next = smx_pkg::AOP_DIV;
                                endcase
                            end
                        end
                        default:
                        begin
                            trap_next = smx_pkg::TRAP_ILLEGAL;
                        end
                    endcase
                end
            end
            smx_pkg::S_LOAD:
            begin
                alu_req.start = 1'b1;
                state_next    = smx_pkg::S_BUSY;
            end
            smx_pkg::S_BUSY:
            begin
                if (alu_done)
                begin
                    top_next   = alu_result;
                    depth_next = depth_reg - DW'(1);
                    state_next = smx_pkg::S_DONE;
                end
            end
            smx_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.trap      = trap_reg;
                    rsp_next.top_value = (depth_reg == '0) ? '0 : top_reg;
                    rsp_next.depth     = depth_wide[OW-1:0];
                    rsp_valid_next     = 1'b1;
                    state_next         = smx_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smx_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/smx_ram.sv @@
// ----------------------------------------------------------------------------
// smx_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = smx_pkg::WORD_W,
    parameter int DEPTH = smx_pkg::STACK_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/smx_alu.sv @@
// ----------------------------------------------------------------------------
// smx_alu: shared iterative arithmetic unit
// Add and subtract in one step, shift-add multiply and restoring signed
// divide one bit per cycle; done pulses for one cycle with the result.
// ----------------------------------------------------------------------------
module smx_alu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smx_pkg::smx_alu_req_t       req,
    input  logic [smx_pkg::WORD_W-1:0]  a,
    input  logic [smx_pkg::WORD_W-1:0]  b,
    output logic                        done,
    output logic [smx_pkg::WORD_W-1:0]  result
);

    localparam int W  = smx_pkg::WORD_W;
    localparam int CW = $clog2(W);

    smx_pkg::smx_alu_state_t state_reg, state_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smx_pkg::ALU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, y_reg[W-1]} - {1'b0, x_reg};

        unique case (state_reg)
            smx_pkg::ALU_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        smx_pkg::AOP_ADD:
                        begin
                            acc_next  = a + b;
                            done_next = 1'b1;
                        end
                        smx_pkg::AOP_SUB:
                        begin
                            acc_next  = a - b;
                            done_next = 1'b1;
                        end
                        smx_pkg::AOP_MUL:
                        begin
                            acc_next   = '0;
                            x_next     = a;
                            y_next     = b;
                            cnt_next   = '0;
                            state_next = smx_pkg::ALU_MUL;
                        end
                        smx_pkg::AOP_DIV:
                        begin
                            y_next     = a;
                            x_next     = b;
                            state_next = smx_pkg::ALU_DIV_PREP;
                        end
                        default:
                        begin
                            state_next = smx_pkg::ALU_IDLE;
                        end
                    endcase
                end
            end
            smx_pkg::ALU_MUL:
            begin
                if (y_reg[0])
                begin
                    acc_next = acc_reg + x_reg;
                end
                x_next   = {x_reg[W-2:0], 1'b0};
                y_next   = {1'b0, y_reg[W-1:1]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = smx_pkg::ALU_IDLE;
                end
            end
            smx_pkg::ALU_DIV_PREP:
            begin
                neg_next   = y_reg[W-1] ^ x_reg[W-1];
                y_next     = y_reg[W-1] ? ('0 - y_reg) : y_reg;
                x_next     = x_reg[W-1] ? ('0 - x_reg) : x_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = smx_pkg::ALU_DIV;
            end
            smx_pkg::ALU_DIV:
            begin
                if (!trial[W])
                begin
                    rem_next = trial[W-1:0];
                    y_next   = {y_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[W-2:0], y_reg[W-1]};
                    y_next   = {y_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    state_next = smx_pkg::ALU_DIV_FIX;
                end
            end
            smx_pkg::ALU_DIV_FIX:
            begin
                acc_next   = neg_reg ? ('0 - y_reg) : y_reg;
                done_next  = 1'b1;
                state_next = smx_pkg::ALU_IDLE;
            end
            default:
            begin
                state_next = smx_pkg::ALU_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

@@ dv/stack_machine_execute_step_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_step_tb: regression for the stack machine execute step
// Drives instruction items through the command channel with random gaps and
// checks every response item against a stack model kept in the testbench,
// covering traps, wrapping arithmetic, division corners and a full stack.
// ----------------------------------------------------------------------------
module stack_machine_execute_step_tb;

    localparam int          CLK_HALF    = 4;
    localparam int          RESET_CYCLES = 5;
    localparam int          MIXED_HEAD  = 500;
    localparam int          FILL_PUSHES = 1040;
    localparam int          MIXED_TAIL  = 60;
    localparam int          HOLD_OFF    = 250;
    localparam int          STALL_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 8;
    localparam int          WW          = smx_pkg::WORD_W;
    localparam logic [WW-1:0] WORD_MIN = {1'b1, {(WW-1){1'b0}}};
    localparam logic [WW-1:0] WORD_MAX = {1'b0, {(WW-1){1'b1}}};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    smx_pkg::smx_cmd_t cmd       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    smx_pkg::smx_rsp_t rsp;

    smx_pkg::smx_cmd_t cmd_plan[$];
    smx_pkg::smx_rsp_t expected_steps[$];
    logic [WW-1:0]     model_stack[smx_pkg::STACK_DEPTH];
    int unsigned       model_depth = 0;

    int send_gap     = 0;
    int send_calm    = 0;
    int recv_hold    = 0;
    int recv_calm    = 0;
    int cmds_sent    = 0;
    int rsps_seen    = 0;
    int error_count  = 0;
    int stall_cycles = 0;
    int deepest      = 0;
    int trap_seen[5] = '{default: 0};

    stack_machine_execute_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #CLK_HALF clk = ~clk;

    function automatic smx_pkg::smx_rsp_t execute_step(input smx_pkg::smx_cmd_t c);
        smx_pkg::smx_rsp_t          r;
        logic [smx_pkg::TRAP_W-1:0] tr;
        logic [WW-1:0]              a;
        logic [WW-1:0]              b;
        logic [WW-1:0]              mag_a;
        logic [WW-1:0]              mag_b;
        logic [WW-1:0]              res;
        tr  = smx_pkg::TRAP_NONE;
        res = '0;
        if (c.kind == smx_pkg::KIND_PUSH) begin
            if (model_depth >= smx_pkg::STACK_DEPTH) begin
                tr = smx_pkg::TRAP_OVER;
            end
            else begin
                model_stack[model_depth] = c.operand;
                model_depth++;
            end
        end
        else if (c.kind <= smx_pkg::KIND_DIV) begin
            if (model_depth < 2) begin
                tr = smx_pkg::TRAP_UNDER;
            end
            else begin
                a = model_stack[model_depth-2];
                b = model_stack[model_depth-1];
                case (c.kind)
                    smx_pkg::KIND_ADD: res = a + b;
                    smx_pkg::KIND_SUB: res = a - b;
                    smx_pkg::KIND_MUL: res = a * b;
                    default:
                    begin
                        if (b == '0) begin
                            tr = smx_pkg::TRAP_DIVZERO;
                        end
                        else begin
                            mag_a = a[WW-1] ? -a : a;
                            mag_b = b[WW-1] ? -b : b;
                            res   = mag_a / mag_b;
                            if (a[WW-1] != b[WW-1])
                                res = -res;
                        end
                    end
                endcase
                if (tr == smx_pkg::TRAP_NONE) begin
                    model_stack[model_depth-2] = res;
                    model_depth--;
                end
            end
        end
        else begin
            tr = smx_pkg::TRAP_ILLEGAL;
        end
        r.trap      = tr;
        r.top_value = (model_depth > 0) ? model_stack[model_depth-1] : '0;
        r.depth     = model_depth[smx_pkg::DEPTH_OUT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 64'd1;
            2:       return '1;
            3:       return WORD_MIN;
            4:       return WORD_MAX;
            5:       return $signed($urandom_range(0, 200)) - 64'sd100;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic plan_cmd(input logic [smx_pkg::KIND_W-1:0] kind,
                            input logic [WW-1:0] value);
        smx_pkg::smx_cmd_t c;
        c.kind    = kind;
        c.operand = value;
        cmd_plan.push_back(c);
    endtask

    task automatic plan_mixed(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                plan_cmd(smx_pkg::KIND_PUSH, pick_operand());
            else if (roll < 60)
                plan_cmd(smx_pkg::KIND_ADD, pick_operand());
            else if (roll < 70)
                plan_cmd(smx_pkg::KIND_SUB, pick_operand());
            else if (roll < 80)
                plan_cmd(smx_pkg::KIND_MUL, pick_operand());
            else if (roll < 92)
                plan_cmd(smx_pkg::KIND_DIV, pick_operand());
            else
                plan_cmd(smx_pkg::KIND_W'($urandom_range(5, 7)), pick_operand());
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            send_gap  = 0;
        end
        else begin
            if (cmd_valid && cmd_ready) begin
                expected_steps.push_back(execute_step(cmd));
                void'(cmd_plan.pop_front());
                cmds_sent++;
                send_gap = pick_gap(send_calm);
            end
            if (!cmd_valid || cmd_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_plan.size() > 0) begin
                    cmd_valid <= 1'b1;
                    cmd       <= cmd_plan[0];
                end
                else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        smx_pkg::smx_rsp_t want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            recv_hold = 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                rsps_seen++;
                if (rsp.trap < 5)
                    trap_seen[rsp.trap]++;
                if (int'(rsp.depth) > deepest)
                    deepest = int'(rsp.depth);
                if (expected_steps.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected item: trap %0d top %h depth %0d",
                             $time, rsp.trap, rsp.top_value, rsp.depth);
                end
                else begin
                    want = expected_steps.pop_front();
                    if (rsp.trap !== want.trap) begin
                        error_count++;
                        $display("%0t: trap mismatch: expected %0d, actual %0d",
                                 $time, want.trap, rsp.trap);
                    end
                    if (rsp.top_value !== want.top_value) begin
                        error_count++;
                        $display("%0t: top_value mismatch: expected %h, actual %h",
                                 $time, want.top_value, rsp.top_value);
                    end
                    if (rsp.depth !== want.depth) begin
                        error_count++;
                        $display("%0t: depth mismatch: expected %0d, actual %0d",
                                 $time, want.depth, rsp.depth);
                    end
                end
                if (rsps_seen == 300 || rsps_seen == 1200)
                    recv_hold = HOLD_OFF;
                else
                    recv_hold = pick_gap(recv_calm);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                rsp_ready <= 1'b0;
            end
            else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d idle cycles.", stall_cycles);
            $display("stack_machine_execute_step regression: fail");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // Directed opening: underflow on an empty and a one-entry stack, the
        // illegal opcodes, wrapping add, minimum divided by minus one, a zero
        // divisor, truncating division of mixed signs and a wrapping multiply.
        plan_cmd(smx_pkg::KIND_ADD, '0);
        plan_cmd(smx_pkg::KIND_W'(5), WORD_MAX);
        plan_cmd(smx_pkg::KIND_W'(6), WORD_MIN);
        plan_cmd(smx_pkg::KIND_W'(7), '1);
        plan_cmd(smx_pkg::KIND_PUSH, WORD_MAX);
        plan_cmd(smx_pkg::KIND_SUB, '0);
        plan_cmd(smx_pkg::KIND_PUSH, 64'd1);
        plan_cmd(smx_pkg::KIND_ADD, '1);
        plan_cmd(smx_pkg::KIND_PUSH, '1);
        plan_cmd(smx_pkg::KIND_DIV, '0);
        plan_cmd(smx_pkg::KIND_PUSH, '0);
        plan_cmd(smx_pkg::KIND_DIV, WORD_MAX);
        plan_cmd(smx_pkg::KIND_MUL, '0);
        plan_cmd(smx_pkg::KIND_PUSH, -64'sd7);
        plan_cmd(smx_pkg::KIND_PUSH, 64'd2);
        plan_cmd(smx_pkg::KIND_DIV, '0);
        plan_cmd(smx_pkg::KIND_SUB, '0);
        plan_cmd(smx_pkg::KIND_PUSH, 64'd7);
        plan_cmd(smx_pkg::KIND_PUSH, -64'sd2);
        plan_cmd(smx_pkg::KIND_DIV, '0);
        plan_cmd(smx_pkg::KIND_MUL, '0);
        plan_cmd(smx_pkg::KIND_PUSH, WORD_MAX);
        plan_cmd(smx_pkg::KIND_PUSH, WORD_MAX);
        plan_cmd(smx_pkg::KIND_MUL, '0);
        plan_cmd(smx_pkg::KIND_PUSH, WORD_MIN);

        plan_mixed(MIXED_HEAD);
        for (int i = 0; i < FILL_PUSHES; i++)
            plan_cmd(smx_pkg::KIND_PUSH, pick_operand());
        plan_mixed(MIXED_TAIL);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_plan.size() != 0 || expected_steps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Executed %0d instructions and checked %0d results, deepest stack %0d.",
                 cmds_sent, rsps_seen, deepest);
        $display("Traps: none %0d, overflow %0d, underflow %0d, illegal %0d, divide %0d.",
                 trap_seen[smx_pkg::TRAP_NONE], trap_seen[smx_pkg::TRAP_OVER],
                 trap_seen[smx_pkg::TRAP_UNDER], trap_seen[smx_pkg::TRAP_ILLEGAL],
                 trap_seen[smx_pkg::TRAP_DIVZERO]);
        if (error_count == 0)
            $display("stack_machine_execute_step regression: pass");
        else
            $display("stack_machine_execute_step regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
src/smx_pkg.sv
src/smx_ram.sv
src/smx_alu.sv
src/stack_machine_execute_step.sv
dv/stack_machine_execute_step_tb.sv
